[src/qslerp_pkg.sv]
package qslerp_pkg;

  localparam int QB       = 30;
  localparam int CORDIC_N = 30;
  localparam int XW       = 34;
  localparam int DW       = 36;

  localparam logic [30:0]          ONE_Q      = 31'h4000_0000;
  localparam logic [30:0]          EPS_Q      = 31'd1074;
  localparam logic signed [XW-1:0] INV_GAIN_Q = 34'sd652032874;
  localparam logic [15:0]          T_ONE      = 16'd32768;

  typedef enum logic [1:0] {
    PATH_INTERP = 2'd0,
    PATH_FIRST  = 2'd1,
    PATH_MID    = 2'd2
  } path_t;

  typedef struct packed {
    path_t       path;
    logic [15:0] frac;
    logic [30:0] d;
    logic [30:0] s;
  } qs_cls_t;

  // arctangent of 2^-k in q30 radians
  function automatic logic signed [XW-1:0] atan_q(input int k);
    logic signed [XW-1:0] v;
    case (k)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/qslerp_fifo.sv]
module qslerp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt == (AW+1)'(DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

[src/qslerp_front.sv]
module qslerp_front import qslerp_pkg::*; #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [4*W-1:0]       a_in,
  input  logic [4*W-1:0]       b_in,
  input  logic [15:0]          frac,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4*W-1:0]       out_a,
  output logic [4*(W+1)-1:0]   out_b,
  output qs_cls_t              out_cls
);

  localparam int NSQ = 31;
  localparam int NST = NSQ + 5;
  localparam int RSH = (2*W >= 34) ? 2*W - 34 : 0;
  localparam int LSH = (2*W < 34) ? 34 - 2*W : 0;
  localparam int EW  = 2*W + 34;
  localparam int BW  = 4*(W+1);
  localparam int CRW = 4*W + BW + 16 + 35 + 1;
  localparam int OFS_D = 1;
  localparam int OFS_T = 36;
  localparam int OFS_B = 52;
  localparam int OFS_A = 52 + BW;

  logic           en;
  logic [NST-1:0] vld;

  logic [4*W-1:0]          a1;
  logic [15:0]             t1;
  logic signed [2*W-1:0]   p1 [4];
  logic [4*W-1:0]          b1;

  logic signed [EW-1:0]    pe [4];
  logic signed [DW-1:0]    q30 [4];
  logic signed [DW-1:0]    dsum;
  logic [DW-1:0]           dabs;
  logic signed [W:0]       bx [4];
  logic [BW-1:0]           bn_flat;

  logic [CRW-1:0] cr2;
  logic [CRW-1:0] cr3;
  logic [CRW-1:0] cr4;
  logic [59:0]    sq3;
  logic [61:0]    v4;
  logic [29:0]    dl;
  logic [30:0]    diff;

  logic [34:0]    rem  [1:NSQ-1];
  logic [30:0]    root [1:NSQ];
  logic [61:0]    vs   [1:NSQ-1];
  logic [CRW-1:0] crq  [1:NSQ];

  assign en        = !vld[NST-1] || !out_stall;
  assign full      = !en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], push};
    end
  end

  // component products
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_in;
      b1 <= b_in;
      t1 <= (frac > T_ONE) ? T_ONE : frac;
      for (int i = 0; i < 4; i++) begin
        p1[i] <= $signed(a_in[i*W +: W]) * $signed(b_in[i*W +: W]);
      end
    end
  end

  // dot product in q30, shortest-arc fold
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pe[i]  = EW'(p1[i]);
      q30[i] = DW'((pe[i] >>> RSH) <<< LSH);
    end
    dsum = q30[0] + q30[1] + q30[2] + q30[3];
    dabs = dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
    for (int i = 0; i < 4; i++) begin
      bx[i] = $signed({b1[i*W + W - 1], b1[i*W +: W]});
      bn_flat[i*(W+1) +: W+1] = dsum[DW-1] ? -bx[i] : bx[i];
    end
  end

  assign dl   = cr3[OFS_D +: 30];
  assign diff = ONE_Q - {1'b0, sq3[59:30]};

  always_ff @(posedge clk) begin
    if (en) begin
      cr2 <= {a1, bn_flat, t1, dabs[34:0], (dabs >= DW'(ONE_Q))};
      cr3 <= cr2;
      sq3 <= 60'(cr2[OFS_D +: 30]) * 60'(cr2[OFS_D +: 30]);
      cr4 <= {cr3[CRW-1:OFS_D+30], dl, cr3[0]};
      v4  <= {1'b0, diff, 30'b0};
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    logic [34:0]    r_in;
    logic [30:0]    q_in;
    logic [61:0]    v_in;
    logic [CRW-1:0] c_in;
    logic [34:0]    rx;
    logic [32:0]    tr;
    logic           take;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign v_in = v4;
      assign c_in = cr4;
    end else begin : g_rest
      assign r_in = rem[j];
      assign q_in = root[j];
      assign v_in = vs[j];
      assign c_in = crq[j];
    end

    assign rx   = {r_in[32:0], v_in[61:60]};
    assign tr   = {q_in, 2'b01};
    assign take = rx >= {2'b00, tr};

    always_ff @(posedge clk) begin
      if (en) begin
        root[j+1] <= {q_in[29:0], take};
        crq[j+1]  <= c_in;
      end
    end

    if (j < NSQ - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= take ? rx - {2'b00, tr} : rx;
          vs[j+1]  <= {v_in[59:0], 2'b00};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a        <= crq[NSQ][OFS_A +: 4*W];
      out_b        <= crq[NSQ][OFS_B +: BW];
      out_cls.frac <= crq[NSQ][OFS_T +: 16];
      out_cls.d    <= crq[NSQ][OFS_D +: 31];
      out_cls.s    <= root[NSQ];
      if (crq[NSQ][0]) begin
        out_cls.path <= PATH_FIRST;
      end else if (root[NSQ] < EPS_Q) begin
        out_cls.path <= PATH_MID;
      end else begin
        out_cls.path <= PATH_INTERP;
      end
    end
  end

endmodule

[src/qslerp_back.sv]
module qslerp_back import qslerp_pkg::*; #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_take,
  input  logic [4*W-1:0]     in_a,
  input  logic [4*(W+1)-1:0] in_b,
  input  qs_cls_t            in_cls,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4*W-1:0]     out_r,
  output path_t              out_path
);

  localparam int BW    = 4*(W+1);
  localparam int CRW   = 4*W + BW + 49;
  localparam int OFS_S = 2;
  localparam int OFS_T = 33;
  localparam int OFS_B = 49;
  localparam int OFS_A = 49 + BW;
  localparam int ND    = 31;
  localparam int NB    = 2*CORDIC_N + ND + 6;
  localparam logic signed [W+33:0] SMAX = {{35{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W+33:0] SMIN = {{35{1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W+33:0] RND  = {{(W+4){1'b0}}, 30'h2000_0000};

  logic          en;
  logic [NB-1:0] vld;

  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic [CRW-1:0]       cr0;

  logic signed [XW-1:0] xv  [1:CORDIC_N];
  logic signed [XW-1:0] yv  [1:CORDIC_N];
  logic signed [XW-1:0] zv  [1:CORDIC_N];
  logic [CRW-1:0]       cra [1:CORDIC_N];

  logic [16:0]          ua;
  logic signed [XW+17:0] pa;
  logic signed [XW+17:0] pb;
  logic signed [XW-1:0] zs0 [2];
  logic [CRW-1:0]       crs0;

  logic signed [XW-1:0] xs  [2][1:CORDIC_N];
  logic signed [XW-1:0] ys  [2][1:CORDIC_N];
  logic signed [XW-1:0] zs  [2][1:CORDIC_N];
  logic [CRW-1:0]       crs [1:CORDIC_N];

  logic [33:0]          rem0 [2];
  logic [1:0]           fl0  [2];
  logic [CRW-1:0]       crp;

  logic [33:0]          rm  [2][1:ND];
  logic [30:0]          qd  [2][1:ND];
  logic [1:0]           fd  [2][1:ND];
  logic [CRW-1:0]       crd [1:ND];

  logic [30:0]          rat [2];
  logic [CRW-1:0]       crc;

  logic signed [W+31:0] ma [4];
  logic signed [W+32:0] mb [4];
  logic [CRW-1:0]       crm;

  logic signed [W+33:0] acc [4];
  logic signed [W+33:0] mdp [4];
  logic [W-1:0]         r_int [4];
  logic [W-1:0]         r_mid [4];

  function automatic logic [W-1:0] sat_w(input logic signed [W+33:0] v);
    logic [W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  assign en        = !vld[NB-1] || !out_stall;
  assign in_take   = en && in_valid;
  assign out_valid = vld[NB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= XW'(in_cls.d);
      y0  <= XW'(in_cls.s);
      cr0 <= {in_a, in_b, in_cls.frac, in_cls.s, in_cls.path};
    end
  end

  // vectoring: half angle from (d, s)
  for (genvar k = 0; k < CORDIC_N; k++) begin : g_atan
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [XW-1:0] zi;
    logic [CRW-1:0]       ci;

    if (k == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = '0;
      assign ci = cr0;
    end else begin : g_rest
      assign xi = xv[k];
      assign yi = yv[k];
      assign zi = zv[k];
      assign ci = cra[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cra[k+1] <= ci;
        if (!yi[XW-1]) begin
          xv[k+1] <= xi + (yi >>> k);
          yv[k+1] <= yi - (xi >>> k);
          zv[k+1] <= zi + atan_q(k);
        end else begin
          xv[k+1] <= xi - (yi >>> k);
          yv[k+1] <= yi + (xi >>> k);
          zv[k+1] <= zi - atan_q(k);
        end
      end
    end
  end

  // angle scaling by (1 - t) and t
  assign ua = 17'(T_ONE) - 17'(cra[CORDIC_N][OFS_T +: 16]);
  assign pa = zv[CORDIC_N] * $signed({1'b0, ua});
  assign pb = zv[CORDIC_N] * $signed({2'b00, cra[CORDIC_N][OFS_T +: 16]});

  always_ff @(posedge clk) begin
    if (en) begin
      zs0[0] <= XW'(pa >>> 15);
      zs0[1] <= XW'(pb >>> 15);
      crs0   <= cra[CORDIC_N];
    end
  end

  // rotation lanes: sine of each scaled angle
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar k = 0; k < CORDIC_N; k++) begin : g_sin
      logic signed [XW-1:0] xi;
      logic signed [XW-1:0] yi;
      logic signed [XW-1:0] zi;

      if (k == 0) begin : g_first
        assign xi = INV_GAIN_Q;
        assign yi = '0;
        assign zi = zs0[l];
      end else begin : g_rest
        assign xi = xs[l][k];
        assign yi = ys[l][k];
        assign zi = zs[l][k];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (!zi[XW-1]) begin
            xs[l][k+1] <= xi - (yi >>> k);
            ys[l][k+1] <= yi + (xi >>> k);
            zs[l][k+1] <= zi - atan_q(k);
          end else begin
            xs[l][k+1] <= xi + (yi >>> k);
            ys[l][k+1] <= yi - (xi >>> k);
            zs[l][k+1] <= zi + atan_q(k);
          end
        end
      end
    end
  end

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_sin_carry
    always_ff @(posedge clk) begin
      if (en) begin
        crs[k+1] <= (k == 0) ? crs0 : crs[(k == 0) ? 1 : k];
      end
    end
  end

  // divide prep: negative sine, quotient of two or more
  always_ff @(posedge clk) begin
    if (en) begin
      crp <= crs[CORDIC_N];
      for (int l = 0; l < 2; l++) begin
        rem0[l] <= 34'(ys[l][CORDIC_N][XW-2:0]);
        fl0[l]  <= {ys[l][CORDIC_N][XW-1],
                    !ys[l][CORDIC_N][XW-1] &&
                    (ys[l][CORDIC_N][XW-2:0] >= {crs[CORDIC_N][OFS_S +: 31], 1'b0})};
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar l = 0; l < 2; l++) begin : g_dlane
    for (genvar j = 0; j < ND; j++) begin : g_div
      logic [33:0]    ri;
      logic [30:0]    qi;
      logic [1:0]     fi;
      logic [CRW-1:0] ci;
      logic [33:0]    cand;
      logic [33:0]    sv;
      logic           ge;

      if (j == 0) begin : g_first
        assign ri   = rem0[l];
        assign qi   = '0;
        assign fi   = fl0[l];
        assign ci   = crp;
        assign cand = ri;
      end else begin : g_rest
        assign ri   = rm[l][j];
        assign qi   = qd[l][j];
        assign fi   = fd[l][j];
        assign ci   = crd[j];
        assign cand = {ri[32:0], 1'b0};
      end

      assign sv = 34'(ci[OFS_S +: 31]);
      assign ge = cand >= sv;

      always_ff @(posedge clk) begin
        if (en) begin
          rm[l][j+1] <= ge ? cand - sv : cand;
          qd[l][j+1] <= {qi[29:0], ge};
          fd[l][j+1] <= fi;
        end
      end

      if (l == 0) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            crd[j+1] <= ci;
          end
        end
      end
    end
  end

  // ratio clamp to [0, one]
  always_ff @(posedge clk) begin
    if (en) begin
      crc <= crd[ND];
      for (int l = 0; l < 2; l++) begin
        if (fd[l][ND][1]) begin
          rat[l] <= '0;
        end else if (fd[l][ND][0] || (qd[l][ND] > ONE_Q)) begin
          rat[l] <= ONE_Q;
        end else begin
          rat[l] <= qd[l][ND];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crm <= crc;
      for (int i = 0; i < 4; i++) begin
        ma[i] <= $signed(crc[OFS_A + i*W +: W]) * $signed({1'b0, rat[0]});
        mb[i] <= $signed(crc[OFS_B + i*(W+1) +: W+1]) * $signed({1'b0, rat[1]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i]   = (W+34)'(ma[i]) + (W+34)'(mb[i]) + RND;
      r_int[i] = sat_w(acc[i] >>> QB);
      mdp[i]   = ((W+34)'($signed(crm[OFS_A + i*W +: W])) +
                  (W+34)'($signed(crm[OFS_B + i*(W+1) +: W+1]))) >>> 1;
      r_mid[i] = sat_w(mdp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_path <= path_t'(crm[1:0]);
      for (int i = 0; i < 4; i++) begin
        case (path_t'(crm[1:0]))
          PATH_FIRST: out_r[i*W +: W] <= crm[OFS_A + i*W +: W];
          PATH_MID:   out_r[i*W +: W] <= r_mid[i];
          default:    out_r[i*W +: W] <= r_int[i];
        endcase
      end
    end
  end

endmodule

[src/quaternion_slerp_unit.sv]
// quaternion slerp, one interpolation per item
// input side is a queue: drive a_*, b_*, frac and raise push; the item is
// taken at a clock edge with push high and full low. frac is unsigned
// q1.15, values above one are treated as one
// result side is a queue: while empty is low the oldest result sits on
// r_x..r_w and path; it is taken at an edge with pop high
// path: 0 interpolated, 1 first quaternion returned, 2 midpoint
// throughput is one item per cycle while full stays low; the accepting edge
// loads the first of 36 front stages (dot product and square root), then the
// item passes the middle queue, 97 back stages (arctangent, two sine lanes,
// two dividers, weighting multiplies) and the output queue
// the front and back each stall as a whole only when the queue after them
// is full, so a held pop fills the output queue, then the back, the middle
// queue and the front, and then full rises
// synchronous reset empties both queues and clears all stage valids
module quaternion_slerp_unit import qslerp_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w,
  input  logic [15:0]                       frac,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [COMPONENT_WIDTH-1:0] r_x,
  output logic signed [COMPONENT_WIDTH-1:0] r_y,
  output logic signed [COMPONENT_WIDTH-1:0] r_z,
  output logic signed [COMPONENT_WIDTH-1:0] r_w,
  output logic [1:0]                        path
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int BW  = 4*(W+1);
  localparam int MW  = 4*W + BW + $bits(qs_cls_t);
  localparam int OW  = 4*W + 2;

  logic [4*W-1:0] f_a;
  logic [BW-1:0]  f_b;
  qs_cls_t        f_cls;
  logic           f_valid;
  logic           mid_full;
  logic           mid_empty;
  logic [MW-1:0]  mid_rdata;
  logic           b_take;
  logic           b_valid;
  logic           out_full;
  logic [4*W-1:0] b_r;
  path_t          b_path;
  logic [OW-1:0]  out_rdata;

  qslerp_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .a_in      ({a_w, a_z, a_y, a_x}),
    .b_in      ({b_w, b_z, b_y, b_x}),
    .frac      (frac),
    .out_valid (f_valid),
    .out_stall (mid_full),
    .out_a     (f_a),
    .out_b     (f_b),
    .out_cls   (f_cls)
  );

  qslerp_fifo #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .wdata ({f_a, f_b, f_cls}),
    .full  (mid_full),
    .pop   (b_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  qslerp_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mid_empty),
    .in_take   (b_take),
    .in_a      (mid_rdata[MW-1 -: 4*W]),
    .in_b      (mid_rdata[$bits(qs_cls_t) +: BW]),
    .in_cls    (qs_cls_t'(mid_rdata[$bits(qs_cls_t)-1:0])),
    .out_valid (b_valid),
    .out_stall (out_full),
    .out_r     (b_r),
    .out_path  (b_path)
  );

  qslerp_fifo #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .wdata ({b_path, b_r}),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign r_x  = out_rdata[0*W +: W];
  assign r_y  = out_rdata[1*W +: W];
  assign r_z  = out_rdata[2*W +: W];
  assign r_w  = out_rdata[3*W +: W];
  assign path = out_rdata[OW-1 -: 2];

`ifndef SYNTH
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> (f_valid && mid_full))
    else $error("input blocked while the front can drain");

  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !mid_full) |=> !mid_empty)
    else $error("front item lost at the middle queue");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !out_full) |=> !empty)
    else $error("back item lost at the output queue");
`endif

endmodule
